FILE: src/arh_pkg.sv
package arh_pkg;

  localparam int unsigned MaxSamples  = 4096;
  localparam int unsigned MaxBins     = 64;
  localparam int unsigned SampleWidth = 32;
  localparam int unsigned BinSetWidth = 7;
  localparam int unsigned BinIdxWidth = 6;
  localparam int unsigned TotalWidth  = 13;
  localparam logic [BinSetWidth-1:0] BinSetReset = 7'd16;

  typedef enum logic [1:0] {
    StatNormal = 2'd0,
    StatZeroRange = 2'd1,
    StatEmpty = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [SampleWidth-1:0] sample;
    logic include_req;
    logic last_sample;
  } in_item_t;

  typedef struct packed {
    logic [BinIdxWidth-1:0] bin_index;
    logic [TotalWidth-1:0] bin_total;
    logic signed [SampleWidth-1:0] lower_edge;
    logic signed [SampleWidth-1:0] upper_edge;
    logic signed [SampleWidth-1:0] data_min;
    logic signed [SampleWidth-1:0] data_max;
    logic [1:0] status;
    logic final_bin;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StRead,
    StWait,
    StDiv,
    StCount,
    StEdgeLo,
    StEdgeHi,
    StEmit,
    StSpecial
  } state_e;

  typedef struct packed {
    logic load;
    logic clr_bins;
    logic rd_start;
    logic div_start;
    logic count;
    logic edge_lo;
    logic edge_hi;
    logic emit_load;
    logic special_load;
    logic next_bin;
    logic next_sample;
    logic end_set;
  } cmd_t;

  typedef struct packed {
    logic last_in;
    logic empty;
    logic zero_range;
    logic div_done;
    logic samples_done;
    logic bins_clear_done;
    logic bins_done;
    logic out_free;
  } stat_t;

endpackage

FILE: src/arh_ctrl.sv
module arh_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  arh_pkg::stat_t stat_i,
  output arh_pkg::cmd_t  cmd_o
);

  arh_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= arh_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      arh_pkg::StIdle: begin
        if (in_valid_i && stat_i.last_in) state_d = arh_pkg::StClear;
      end
      arh_pkg::StClear: begin
        if (stat_i.bins_clear_done) begin
          if (stat_i.empty || stat_i.zero_range) state_d = arh_pkg::StSpecial;
          else state_d = arh_pkg::StRead;
        end
      end
      arh_pkg::StRead: state_d = arh_pkg::StWait;
      arh_pkg::StWait: state_d = arh_pkg::StDiv;
      arh_pkg::StDiv: begin
        if (stat_i.div_done) state_d = arh_pkg::StCount;
      end
      arh_pkg::StCount: begin
        if (stat_i.samples_done) state_d = arh_pkg::StEdgeLo;
        else state_d = arh_pkg::StRead;
      end
      arh_pkg::StEdgeLo: begin
        if (stat_i.div_done) state_d = arh_pkg::StEdgeHi;
      end
      arh_pkg::StEdgeHi: begin
        if (stat_i.div_done && stat_i.out_free) state_d = arh_pkg::StEmit;
      end
      arh_pkg::StEmit: begin
        if (stat_i.out_free) begin
          if (stat_i.bins_done) state_d = arh_pkg::StIdle;
          else state_d = arh_pkg::StEdgeLo;
        end
      end
      arh_pkg::StSpecial: begin
        if (stat_i.out_free) state_d = arh_pkg::StIdle;
      end
      default: state_d = arh_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      arh_pkg::StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      arh_pkg::StClear: cmd_o.clr_bins = 1'b1;
      arh_pkg::StRead: cmd_o.rd_start = 1'b1;
      arh_pkg::StWait: cmd_o.div_start = 1'b1;
      arh_pkg::StDiv: ;
      arh_pkg::StCount: begin
        cmd_o.count = 1'b1;
        cmd_o.next_sample = 1'b1;
        cmd_o.edge_lo = stat_i.samples_done;
      end
      arh_pkg::StEdgeLo: cmd_o.edge_hi = stat_i.div_done;
      arh_pkg::StEdgeHi: cmd_o.emit_load = stat_i.div_done && stat_i.out_free;
      arh_pkg::StEmit: begin
        if (stat_i.out_free) begin
          cmd_o.next_bin = 1'b1;
          cmd_o.end_set = stat_i.bins_done;
          cmd_o.edge_lo = !stat_i.bins_done;
        end
      end
      arh_pkg::StSpecial: begin
        cmd_o.special_load = stat_i.out_free;
        cmd_o.end_set = stat_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

FILE: src/arh_datapath.sv
module arh_datapath #(
  parameter int unsigned MAX_BINS = arh_pkg::MaxBins
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [arh_pkg::BinSetWidth-1:0]       cfg_data_i,
  input  logic signed [arh_pkg::SampleWidth-1:0] sample_i,
  input  logic                                  include_i,
  input  logic                                  last_i,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic [arh_pkg::BinIdxWidth-1:0]       bin_index_o,
  output logic [arh_pkg::TotalWidth-1:0]        bin_total_o,
  output logic signed [arh_pkg::SampleWidth-1:0] lower_o,
  output logic signed [arh_pkg::SampleWidth-1:0] upper_o,
  output logic signed [arh_pkg::SampleWidth-1:0] min_o,
  output logic signed [arh_pkg::SampleWidth-1:0] max_o,
  output logic [1:0]                            status_o,
  output logic                                  final_o,
  input  arh_pkg::cmd_t                         cmd_i,
  output arh_pkg::stat_t                        stat_o
);

  localparam int unsigned MAX_SAMPLES  = arh_pkg::MaxSamples;
  localparam int unsigned SAMPLE_WIDTH = arh_pkg::SampleWidth;
  localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned BW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned NW = $clog2(MAX_BINS + 1);
  localparam int unsigned DW = SAMPLE_WIDTH + NW;
  localparam int unsigned DCW = $clog2(DW + 1);
  localparam int unsigned TW = arh_pkg::TotalWidth;
  localparam logic signed [SAMPLE_WIDTH-1:0] SMax = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMin = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic [arh_pkg::BinSetWidth-1:0] binset_q;
  logic [SAMPLE_WIDTH-1:0] store [MAX_SAMPLES];
  logic [SAMPLE_WIDTH-1:0] rd_q;
  logic [SAMPLE_WIDTH-1:0] diff;
  logic [CW-1:0] cnt_q, rd_idx_q;
  logic signed [SAMPLE_WIDTH-1:0] min_q, max_q;
  logic [TW-1:0] bins_q [MAX_BINS];
  logic [TW-1:0] cnt_rd_q, emit_rd_q;
  logic [BW-1:0] clr_idx_q, bin_q;
  logic [BW:0] lo_bin;
  logic [NW-1:0] nb;
  logic [SAMPLE_WIDTH-1:0] range;
  logic [DW-1:0] num_q, rem_q, den_q, dend;
  logic [DCW-1:0] dcnt_q;
  logic div_busy_q;
  logic [SAMPLE_WIDTH-1:0] lo_off_q;
  logic [DW:0] rem_sh;
  logic [DW-1:0] num_sh;
  logic [DW-1:0] qclamp;
  logic [BW-1:0] qbin;
  logic ov_q;
  arh_pkg::out_item_t oi_q;
  logic [SAMPLE_WIDTH-1:0] hi_off;
  logic take;

  always_comb begin
    nb = binset_q[NW-1:0];
    if (binset_q == '0) nb = NW'(1);
    else if (32'(binset_q) > MAX_BINS) nb = NW'(MAX_BINS);
  end
  assign range = max_q - min_q;
  assign diff = rd_q - min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) binset_q <= arh_pkg::BinSetReset;
    else if (cfg_we_i) binset_q <= cfg_data_i;
  end

  assign take = cmd_i.load && include_i && (32'(cnt_q) < MAX_SAMPLES);

  always_ff @(posedge clk_i) begin
    if (take) store[cnt_q[AW-1:0]] <= sample_i;
    if (cmd_i.rd_start) rd_q <= store[rd_idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      min_q <= SMax;
      max_q <= SMin;
      rd_idx_q <= '0;
    end else begin
      if (take) begin
        cnt_q <= cnt_q + 1'b1;
        if (sample_i < min_q) min_q <= sample_i;
        if (sample_i > max_q) max_q <= sample_i;
      end
      if (cmd_i.next_sample) rd_idx_q <= rd_idx_q + 1'b1;
      if (cmd_i.end_set) begin
        cnt_q <= '0;
        min_q <= SMax;
        max_q <= SMin;
        rd_idx_q <= '0;
      end
    end
  end

  // bin counters; cleared by sweep at the start of each binning
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
    end else if (cmd_i.clr_bins) begin
      clr_idx_q <= (32'(clr_idx_q) == MAX_BINS - 1) ? '0 : clr_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_bins) bins_q[clr_idx_q] <= '0;
    else if (cmd_i.count) bins_q[qbin] <= cnt_rd_q + 1'b1;
    cnt_rd_q <= bins_q[qbin];
    emit_rd_q <= bins_q[bin_q];
  end

  // restoring divider: num / den
  assign dend = {{NW{1'b0}}, range};
  assign rem_sh = {rem_q, num_q[DW-1]};
  assign num_sh = {num_q[DW-2:0], 1'b0};
  assign lo_bin = {1'b0, bin_q} + {{BW{1'b0}}, cmd_i.next_bin};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      dcnt_q <= '0;
    end else begin
      if (cmd_i.div_start || cmd_i.edge_lo || cmd_i.edge_hi) begin
        div_busy_q <= 1'b1;
        dcnt_q <= DCW'(DW);
      end else if (div_busy_q) begin
        dcnt_q <= dcnt_q - 1'b1;
        if (dcnt_q == DCW'(1)) div_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      num_q <= {{NW{1'b0}}, diff} * DW'(nb);
      rem_q <= '0;
      den_q <= dend;
    end else if (cmd_i.edge_lo) begin
      num_q <= {{NW{1'b0}}, range} * DW'(lo_bin);
      rem_q <= '0;
      den_q <= {{(DW-NW){1'b0}}, nb};
    end else if (cmd_i.edge_hi) begin
      num_q <= {{NW{1'b0}}, range} * DW'({1'b0, bin_q} + 1'b1);
      rem_q <= '0;
      den_q <= {{(DW-NW){1'b0}}, nb};
      lo_off_q <= num_q[SAMPLE_WIDTH-1:0];
    end else if (div_busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= DW'(rem_sh - {1'b0, den_q});
        num_q <= num_sh | DW'(1);
      end else begin
        rem_q <= rem_sh[DW-1:0];
        num_q <= num_sh;
      end
    end
  end

  assign qclamp = (num_q >= {{(DW-NW){1'b0}}, nb}) ? DW'(nb - 1'b1) : num_q;
  assign qbin = qclamp[BW-1:0];
  assign hi_off = num_q[SAMPLE_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bin_q <= '0;
    else if (cmd_i.next_bin) bin_q <= cmd_i.end_set ? '0 : bin_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (cmd_i.emit_load || cmd_i.special_load) ov_q <= 1'b1;
    else if (out_ready_i) ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      oi_q.bin_index  <= 6'(bin_q);
      oi_q.bin_total  <= emit_rd_q;
      oi_q.lower_edge <= min_q + lo_off_q;
      oi_q.upper_edge <= min_q + hi_off;
      oi_q.data_min   <= min_q;
      oi_q.data_max   <= max_q;
      oi_q.status     <= arh_pkg::StatNormal;
      oi_q.final_bin  <= (32'(bin_q) + 1 == 32'(nb));
    end else if (cmd_i.special_load) begin
      oi_q.bin_index <= '0;
      oi_q.final_bin <= 1'b1;
      if (cnt_q == '0) begin
        oi_q.bin_total <= '0;
        oi_q.lower_edge <= '0;
        oi_q.upper_edge <= '0;
        oi_q.data_min <= '0;
        oi_q.data_max <= '0;
        oi_q.status <= arh_pkg::StatEmpty;
      end else begin
        oi_q.bin_total <= TW'(cnt_q);
        oi_q.lower_edge <= min_q;
        oi_q.upper_edge <= max_q;
        oi_q.data_min <= min_q;
        oi_q.data_max <= max_q;
        oi_q.status <= arh_pkg::StatZeroRange;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign bin_index_o = oi_q.bin_index;
  assign bin_total_o = oi_q.bin_total;
  assign lower_o = oi_q.lower_edge;
  assign upper_o = oi_q.upper_edge;
  assign min_o = oi_q.data_min;
  assign max_o = oi_q.data_max;
  assign status_o = oi_q.status;
  assign final_o = oi_q.final_bin;

  always_comb begin
    stat_o = '0;
    stat_o.last_in = last_i;
    stat_o.empty = (cnt_q == '0);
    stat_o.zero_range = (min_q == max_q);
    stat_o.div_done = !div_busy_q;
    stat_o.samples_done = (rd_idx_q + 1'b1 == cnt_q);
    stat_o.bins_clear_done = (32'(clr_idx_q) == MAX_BINS - 1);
    stat_o.bins_done = (32'(bin_q) + 1 == 32'(nb));
    stat_o.out_free = !ov_q || out_ready_i;
  end

endmodule

FILE: src/auto_range_histogram.sv
// Auto-range histogram.
// Input channel (in_valid_i/in_ready_o, in_item_i): one sample per
// transaction with include and last flags. Samples are taken one per cycle
// while the block is collecting a set.
// On the transaction marked last the block stops accepting, clears its
// MAX_BINS bin counters (one per cycle), then reads each stored sample and
// finds its bin with a 39-step bit-serial divider (read, divider start,
// divider steps, count); an empty or zero-range set skips this and gives
// one status transaction. Each bin then takes two divider passes for its
// edges; its result shows once both ran and the previous one was taken.
// Output channel (out_valid_o/out_ready_i, out_item_o): one transaction per
// bin, final_bin on the last. A stalled receiver holds the output register
// and the sequencer waits on it; input stays closed until the last result.
// Configuration: cfg_we_i/cfg_data_i writes the bin count; write only while
// idle. Reset (rst_ni low, async) sets 16 bins and empties the set; the
// sample store needs no clearing.
module auto_range_histogram #(
  parameter int unsigned MAX_BINS = arh_pkg::MaxBins
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [arh_pkg::BinSetWidth-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  arh_pkg::in_item_t               in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output arh_pkg::out_item_t              out_item_o
);

  arh_pkg::cmd_t  cmd;
  arh_pkg::stat_t stat;

  arh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  arh_datapath #(
    .MAX_BINS     (MAX_BINS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (in_item_i.sample),
    .include_i   (in_item_i.include_req),
    .last_i      (in_item_i.last_sample),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .bin_index_o (out_item_o.bin_index),
    .bin_total_o (out_item_o.bin_total),
    .lower_o     (out_item_o.lower_edge),
    .upper_o     (out_item_o.upper_edge),
    .min_o       (out_item_o.data_min),
    .max_o       (out_item_o.data_max),
    .status_o    (out_item_o.status),
    .final_o     (out_item_o.final_bin),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

`ifndef SYNTHESIS
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o)) else $error("output changed");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("output dropped");
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.last_sample |=> !in_ready_o)
    else $error("input open after last");
`endif

endmodule

FILE: tb/auto_range_histogram_test.sv
module auto_range_histogram_test;

  localparam int unsigned WatchLimit = 400000;
  localparam int unsigned SW = arh_pkg::SampleWidth;
  localparam int unsigned TW = arh_pkg::TotalWidth;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [arh_pkg::BinSetWidth-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  arh_pkg::in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  arh_pkg::out_item_t out_item_o;

  always #5 clk_i = ~clk_i;

  auto_range_histogram dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_item_i(in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o(out_item_o)
  );

  // predictor state
  logic [arh_pkg::BinSetWidth-1:0] bin_count_reg;
  logic signed [SW-1:0] kept_samples[$];
  logic signed [SW-1:0] set_min, set_max;

  arh_pkg::in_item_t pending_items[$];
  arh_pkg::out_item_t expected_bins[$];
  int unsigned send_idle_pct, recv_stall_pct, hold_cycles, quiet_cycles;
  bit failed;

  task automatic clear_set();
    kept_samples.delete();
    set_min = {1'b0, {(SW-1){1'b1}}};
    set_max = {1'b1, {(SW-1){1'b0}}};
  endtask

  task automatic predict_histogram(input arh_pkg::in_item_t it);
    arh_pkg::out_item_t r;
    int unsigned nb;
    longint unsigned range, d, q;
    int unsigned totals[arh_pkg::MaxBins];
    if (it.include_req && kept_samples.size() < arh_pkg::MaxSamples) begin
      kept_samples.insert(kept_samples.size(), it.sample);
      if (it.sample < set_min) set_min = it.sample;
      if (it.sample > set_max) set_max = it.sample;
    end
    if (!it.last_sample) return;
    r = '0;
    r.final_bin = 1'b1;
    if (kept_samples.size() == 0) begin
      r.status = arh_pkg::StatEmpty;
      expected_bins.insert(expected_bins.size(), r);
    end else if (set_min == set_max) begin
      r.status = arh_pkg::StatZeroRange;
      r.bin_total = TW'(kept_samples.size());
      r.lower_edge = set_min;
      r.upper_edge = set_max;
      r.data_min = set_min;
      r.data_max = set_max;
      expected_bins.insert(expected_bins.size(), r);
    end else begin
      nb = bin_count_reg;
      if (nb < 1) nb = 1;
      if (nb > arh_pkg::MaxBins) nb = arh_pkg::MaxBins;
      range = longint'(set_max) - longint'(set_min);
      foreach (totals[b]) totals[b] = 0;
      foreach (kept_samples[i]) begin
        d = longint'(kept_samples[i]) - longint'(set_min);
        q = (d * nb) / range;
        if (q >= nb) q = nb - 1;
        totals[q]++;
      end
      for (int unsigned b = 0; b < nb; b++) begin
        r.bin_index = 6'(b);
        r.bin_total = TW'(totals[b]);
        r.lower_edge = SW'(longint'(set_min) + longint'((range * b) / nb));
        r.upper_edge = SW'(longint'(set_min) + longint'((range * (b + 1)) / nb));
        r.data_min = set_min;
        r.data_max = set_max;
        r.status = arh_pkg::StatNormal;
        r.final_bin = (b + 1 == nb);
        expected_bins.insert(expected_bins.size(), r);
      end
    end
    clear_set();
  endtask

  // driver
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) predict_histogram(in_item_i);
    if (!in_valid_i || in_ready_o) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item_i <= pending_items.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    arh_pkg::out_item_t exp_r;
    if (out_valid_o && out_ready_i) begin
      if (expected_bins.size() == 0) begin
        $error("unexpected transaction %p", out_item_o);
        failed = 1'b1;
      end else begin
        exp_r = expected_bins.pop_front();
        if (out_item_o.bin_index !== exp_r.bin_index) begin
          $error("bin_index exp %0d got %0d", exp_r.bin_index, out_item_o.bin_index);
          failed = 1'b1;
        end
        if (out_item_o.bin_total !== exp_r.bin_total) begin
          $error("bin_total exp %0d got %0d", exp_r.bin_total, out_item_o.bin_total);
          failed = 1'b1;
        end
        if (out_item_o.lower_edge !== exp_r.lower_edge) begin
          $error("lower_edge exp %0d got %0d", exp_r.lower_edge, out_item_o.lower_edge);
          failed = 1'b1;
        end
        if (out_item_o.upper_edge !== exp_r.upper_edge) begin
          $error("upper_edge exp %0d got %0d", exp_r.upper_edge, out_item_o.upper_edge);
          failed = 1'b1;
        end
        if (out_item_o.data_min !== exp_r.data_min) begin
          $error("data_min exp %0d got %0d", exp_r.data_min, out_item_o.data_min);
          failed = 1'b1;
        end
        if (out_item_o.data_max !== exp_r.data_max) begin
          $error("data_max exp %0d got %0d", exp_r.data_max, out_item_o.data_max);
          failed = 1'b1;
        end
        if (out_item_o.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, out_item_o.status);
          failed = 1'b1;
        end
        if (out_item_o.final_bin !== exp_r.final_bin) begin
          $error("final_bin exp %0d got %0d", exp_r.final_bin, out_item_o.final_bin);
          failed = 1'b1;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic signed [SW-1:0] rand_sample();
    case ($urandom_range(3))
      0: rand_sample = $urandom;
      1: rand_sample = $signed($urandom_range(2000)) - 1000;
      2: rand_sample = $signed($urandom_range(32'h7fff)) <<< 8;
      default: rand_sample = $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
    endcase
  endfunction

  task automatic add_item(input logic signed [SW-1:0] s, input bit inc,
                          input bit last);
    arh_pkg::in_item_t it;
    it.sample = s;
    it.include_req = inc;
    it.last_sample = last;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic add_random_set(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      add_item(rand_sample(), $urandom_range(9) != 0, i == n - 1);
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && !in_valid_i && expected_bins.size() == 0);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_bins(input logic [arh_pkg::BinSetWidth-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    bin_count_reg = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    failed = 1'b0;
    quiet_cycles = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    bin_count_reg = arh_pkg::BinSetReset;
    clear_set();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: default bin count
    add_item(32'sh8000_0000, 1, 0);
    add_item(32'sh7fff_ffff, 1, 0);
    add_item(0, 1, 0);
    add_item(32'sh1234_5678, 0, 1);
    add_item(5, 0, 1);
    add_item(32'sh0001_0000, 1, 0);
    add_item(32'sh0001_0000, 1, 1);
    add_item(-7, 1, 1);
    add_item(-100, 1, 0);
    add_item(100, 1, 0);
    add_item(-1, 0, 0);
    add_item(33, 1, 1);
    drain();

    write_bins(7'd0);
    add_item(-5, 1, 0);
    add_item(5, 1, 1);
    drain();
    write_bins(7'd127);
    add_item(32'sh8000_0000, 1, 0);
    add_item(-3, 1, 0);
    add_item(32'sh7fff_ffff, 1, 1);
    drain();
    write_bins(7'(arh_pkg::MaxBins));
    add_item(1, 1, 0);
    add_item(2, 1, 0);
    add_item(1000, 1, 1);
    drain();

    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 81; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 81; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      write_bins(ph == 0 ? 7'd1 : 7'($urandom_range(1, 24)));
      if (ph == 2) hold_cycles = 3000;
      for (int s = 0; s < 7; s++) add_random_set($urandom_range(1, 16));
      if (ph == 3) add_random_set(3);
      drain();
    end
    if (expected_bins.size() != 0) failed = 1'b1;
    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
